FILE: rtl/core/mprl_pkg.sv
// ----------------------------------------------------------------------------
// mprl_pkg
// shared types and constants of the memory poison list recorder
// ----------------------------------------------------------------------------
`default_nettype none

package mprl_pkg;

    // default sizes of the design
    localparam int DEF_MAX_UNITS   = 4;
    localparam int DEF_MAX_ENTRIES = 16;

    // number of unit id registers in the register map
    localparam int NUM_UNIT_IDS = 4;

    // limit used when max_entries is written as zero
    localparam int DEFAULT_LIMIT = 8;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // field widths
    localparam int WORD_W   = 64;
    localparam int CNT_W    = 8;
    localparam int SLOT_W   = 2;
    localparam int UCOUNT_W = 3;
    localparam int CFG_IX_W = 3;

    // register indexes
    typedef enum logic [CFG_IX_W-1:0] {
        CFG_MAX_ENTRIES = 3'd0,
        CFG_UNIT_COUNT  = 3'd1,
        CFG_UNIT_ID_0   = 3'd2,
        CFG_UNIT_ID_1   = 3'd3,
        CFG_UNIT_ID_2   = 3'd4,
        CFG_UNIT_ID_3   = 3'd5
    } t_cfg_index;

    // result status codes
    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_DUP     = 3'd1,
        ST_FULL    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_NOT_MEM = 3'd4
    } t_status;

    // classification made by the front
    typedef enum logic [1:0] {
        JOB_NOT_MEM,
        JOB_UNKNOWN,
        JOB_LOOKUP
    } t_job_kind;

    // one classified item on its way to the back
    typedef struct packed {
        t_job_kind          kind;
        logic [SLOT_W-1:0]  slot;
        logic [WORD_W-1:0]  addr;
        logic [WORD_W-1:0]  hw_id;
        logic [WORD_W-1:0]  err_time;
    } t_job;

    // queue status seen by the top and the back
    typedef struct packed {
        logic head_valid;
        logic full;
    } t_queue_status;

    // one stored poison entry
    typedef struct packed {
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] hw_id;
        logic [WORD_W-1:0] err_time;
    } t_entry;

endpackage

`default_nettype wire

FILE: rtl/core/memory_poison_list_recorder_top.sv
// ----------------------------------------------------------------------------
// memory_poison_list_recorder_top
// records memory-error reports into a per-unit poison list
// ----------------------------------------------------------------------------
//  channel   handshake                       payload
//  report    i_start, o_busy                 is_memory_error, package_id,
//                                            err_addr, unit_hw_id, err_time
//  result    o_valid (one-cycle strobe)      status, retire_row, unit_slot,
//                                            entry_index, entry_total
//  config    i_cfg_valid, o_cfg_ready        cfg_index, cfg_data
//
//  an item is taken when i_start is high and o_busy low; results cannot be stalled
//  with the back idle, non-memory and unknown-unit items get their result strobe
//  straight from the queue head, while an item for a known unit is searched first
//  (one entry store read per cycle, each read compared in the cycle after it);
//  o_busy is high while the two-deep job queue is full
//  synchronous active-low reset clears counts, config and control, not the entry store
// ----------------------------------------------------------------------------
`default_nettype none

module memory_poison_list_recorder_top
    import mprl_pkg::*;
#(
    parameter int MAX_UNITS   = DEF_MAX_UNITS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // report channel
    input  wire logic                i_start,
    output logic                     o_busy,
    input  wire logic                i_is_memory_error,
    input  wire logic [WORD_W-1:0]   i_package_id,
    input  wire logic [WORD_W-1:0]   i_err_addr,
    input  wire logic [WORD_W-1:0]   i_unit_hw_id,
    input  wire logic [WORD_W-1:0]   i_err_time,
    // result channel
    output logic                     o_valid,
    output logic [2:0]               o_status,
    output logic                     o_retire_row,
    output logic [SLOT_W-1:0]        o_unit_slot,
    output logic [CNT_W-1:0]         o_entry_index,
    output logic [CNT_W-1:0]         o_entry_total,
    // configuration channel
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_IX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]   i_cfg_data
);

    t_job          front_job;
    t_job          head_job;
    t_queue_status qstat;
    logic [CNT_W-1:0] max_entries;
    logic          push;
    logic          pop;

    // config writes always taken, unchecked; user keeps block idle as they arrive
    assign o_cfg_ready = 1'b1;

    // the queue absorbs items while the back is busy searching
    assign o_busy = qstat.full;
    assign push   = i_start && !qstat.full;

    // front: register file and unit classification
    mprl_front #(
        .MAX_UNITS (MAX_UNITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_is_memory_error (i_is_memory_error),
        .i_package_id      (i_package_id),
        .i_err_addr        (i_err_addr),
        .i_unit_hw_id      (i_unit_hw_id),
        .i_err_time        (i_err_time),
        .o_job             (front_job),
        .o_max_entries     (max_entries)
    );

    // classified jobs wait here for the back
    mprl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (qstat)
    );

    // back: entry search, append and result register
    mprl_back #(
        .MAX_UNITS   (MAX_UNITS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_qstat       (qstat),
        .i_max_entries (max_entries),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_retire_row  (o_retire_row),
        .o_unit_slot   (o_unit_slot),
        .o_entry_index (o_entry_index),
        .o_entry_total (o_entry_total)
    );

endmodule

`default_nettype wire

FILE: rtl/core/mprl_front.sv
// ----------------------------------------------------------------------------
// mprl_front
// configuration registers and classification of incoming reports
// ----------------------------------------------------------------------------
`default_nettype none

module mprl_front
    import mprl_pkg::*;
#(
    parameter int MAX_UNITS = DEF_MAX_UNITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration writes
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_IX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]   i_cfg_data,
    // incoming report
    input  wire logic                i_is_memory_error,
    input  wire logic [WORD_W-1:0]   i_package_id,
    input  wire logic [WORD_W-1:0]   i_err_addr,
    input  wire logic [WORD_W-1:0]   i_unit_hw_id,
    input  wire logic [WORD_W-1:0]   i_err_time,
    // classified job
    output t_job                     o_job,
    output logic [CNT_W-1:0]         o_max_entries
);

    logic [CNT_W-1:0]    r_max_entries;
    logic [UCOUNT_W-1:0] r_unit_count;
    logic [WORD_W-1:0]   r_unit_id [NUM_UNIT_IDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= CNT_W'(DEFAULT_LIMIT);
            r_unit_count  <= UCOUNT_W'(1);
            for (int k = 0; k < NUM_UNIT_IDS; k++) begin
                r_unit_id[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index) inside
                CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[CNT_W-1:0];
                CFG_UNIT_COUNT:  r_unit_count  <= i_cfg_data[UCOUNT_W-1:0];
                [CFG_UNIT_ID_0:CFG_UNIT_ID_3]: begin
                    r_unit_id[SLOT_W'(i_cfg_index - CFG_UNIT_ID_0)] <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    // lowest matching slot wins, slots past unit_count never match
    logic              found;
    logic [SLOT_W-1:0] slot;

    always_comb begin
        found = 1'b0;
        slot  = '0;
        for (int u = MAX_UNITS - 1; u >= 0; u--) begin
            if ((UCOUNT_W'(u) < r_unit_count) && (r_unit_id[u] == i_package_id)) begin
                found = 1'b1;
                slot  = SLOT_W'(u);
            end
        end
    end

    always_comb begin
        o_job.slot     = slot;
        o_job.addr     = i_err_addr;
        o_job.hw_id    = i_unit_hw_id;
        o_job.err_time = i_err_time;
        if (!i_is_memory_error) begin
            o_job.kind = JOB_NOT_MEM;
        end else if (!found) begin
            o_job.kind = JOB_UNKNOWN;
        end else begin
            o_job.kind = JOB_LOOKUP;
        end
    end

    assign o_max_entries = r_max_entries;

endmodule

`default_nettype wire

FILE: rtl/core/mprl_queue.sv
// ----------------------------------------------------------------------------
// mprl_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mprl_queue
    import mprl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_job       i_job,
    input  wire logic  i_pop,
    output t_job       o_head,
    output t_queue_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_fill;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_fill != CNT_QW'(QUEUE_DEPTH));
    assign do_pop  = i_pop && (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_head              = r_mem[r_rd_ptr];
    assign o_status.head_valid = (r_fill != '0);
    assign o_status.full       = (r_fill == CNT_QW'(QUEUE_DEPTH));

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("job pushed into a full queue");
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_fill != '0) && (r_fill <= CNT_QW'(QUEUE_DEPTH)))
        else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/mprl_back.sv
// ----------------------------------------------------------------------------
// mprl_back
// serial search of the unit's poison entries, append and result
// ----------------------------------------------------------------------------
`default_nettype none

module mprl_back
    import mprl_pkg::*;
#(
    parameter int MAX_UNITS   = DEF_MAX_UNITS,
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_job                   i_job,
    input  t_queue_status          i_qstat,
    input  wire logic [CNT_W-1:0]  i_max_entries,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [2:0]             o_status,
    output logic                   o_retire_row,
    output logic [SLOT_W-1:0]      o_unit_slot,
    output logic [CNT_W-1:0]       o_entry_index,
    output logic [CNT_W-1:0]       o_entry_total
);

    localparam int DEPTH = MAX_UNITS * MAX_ENTRIES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state            r_state,  n_state;
    logic [SLOT_W-1:0] r_slot,   n_slot;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic [CNT_W-1:0]  r_issue,  n_issue;
    logic              r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [WORD_W-1:0] r_addr,   n_addr;
    logic [WORD_W-1:0] r_hw_id,  n_hw_id;
    logic [WORD_W-1:0] r_time,   n_time;
    logic [CNT_W-1:0]  r_count [MAX_UNITS];

    logic              r_valid,  n_valid;
    t_status           r_status, n_status;
    logic              r_retire, n_retire;
    logic [SLOT_W-1:0] r_uslot,  n_uslot;
    logic [CNT_W-1:0]  r_index,  n_index;
    logic [CNT_W-1:0]  r_total,  n_total;

    t_entry            r_mem [DEPTH];
    t_entry            r_rd_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              cnt_we;

    // limit in force: zero means default, capped at store depth per unit
    logic [CNT_W-1:0]  limit;
    always_comb begin
        limit = (i_max_entries == '0) ? CNT_W'(DEFAULT_LIMIT) : i_max_entries;
        if (limit > CNT_W'(MAX_ENTRIES)) begin
            limit = CNT_W'(MAX_ENTRIES);
        end
    end

    logic match;
    assign match = r_cmp_vld && (r_rd_data.addr == r_addr) && (r_rd_data.hw_id == r_hw_id);

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_issue   = r_issue;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_addr    = r_addr;
        n_hw_id   = r_hw_id;
        n_time    = r_time;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_retire  = r_retire;
        n_uslot   = r_uslot;
        n_index   = r_index;
        n_total   = r_total;
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = AW'(int'(r_slot) * MAX_ENTRIES + int'(r_issue));
        wr_en     = 1'b0;
        wr_addr   = AW'(int'(r_slot) * MAX_ENTRIES + int'(r_cnt));
        cnt_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_qstat.head_valid) begin
                    o_pop = 1'b1;
                    case (i_job.kind)
                        JOB_NOT_MEM: begin
                            n_valid  = 1'b1;
                            n_status = ST_NOT_MEM;
                            n_retire = 1'b0;
                            n_uslot  = '0;
                            n_index  = '0;
                            n_total  = '0;
                        end
                        JOB_UNKNOWN: begin
                            n_valid  = 1'b1;
                            n_status = ST_UNKNOWN;
                            n_retire = 1'b1;
                            n_uslot  = '0;
                            n_index  = '0;
                            n_total  = '0;
                        end
                        default: begin
                            n_state = S_SEARCH;
                            n_slot  = i_job.slot;
                            n_cnt   = r_count[i_job.slot[SW-1:0]];
                            n_issue = '0;
                            n_addr  = i_job.addr;
                            n_hw_id = i_job.hw_id;
                            n_time  = i_job.err_time;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (match) begin
                    n_valid  = 1'b1;
                    n_status = ST_DUP;
                    n_retire = 1'b1;
                    n_uslot  = r_slot;
                    n_index  = r_cmp_idx;
                    n_total  = r_cnt;
                    n_state  = S_IDLE;
                end else if (r_issue < r_cnt) begin
                    // read entry issue now, compare it next cycle
                    rd_en     = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_issue;
                    n_issue   = r_issue + 1'b1;
                end else begin
                    n_valid  = 1'b1;
                    n_retire = 1'b1;
                    n_uslot  = r_slot;
                    n_state  = S_IDLE;
                    if (r_cnt >= limit) begin
                        n_status = ST_FULL;
                        n_index  = '0;
                        n_total  = r_cnt;
                    end else begin
                        wr_en    = 1'b1;
                        cnt_we   = 1'b1;
                        n_status = ST_STORED;
                        n_index  = r_cnt;
                        n_total  = r_cnt + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_valid   <= 1'b0;
            for (int k = 0; k < MAX_UNITS; k++) begin
                r_count[k] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_valid   <= n_valid;
            if (cnt_we) begin
                r_count[r_slot[SW-1:0]] <= r_cnt + 1'b1;
            end
        end
        r_slot    <= n_slot;
        r_cnt     <= n_cnt;
        r_issue   <= n_issue;
        r_cmp_idx <= n_cmp_idx;
        r_addr    <= n_addr;
        r_hw_id   <= n_hw_id;
        r_time    <= n_time;
        r_status  <= n_status;
        r_retire  <= n_retire;
        r_uslot   <= n_uslot;
        r_index   <= n_index;
        r_total   <= n_total;
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= '{addr: r_addr, hw_id: r_hw_id, err_time: r_time};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_retire_row  = r_retire;
    assign o_unit_slot   = r_uslot;
    assign o_entry_index = r_index;
    assign o_entry_total = r_total;

`ifndef ASSERT_OFF
    a_stored_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == ST_STORED)) |-> (r_total == r_index + 1'b1))
        else $error("stored result total does not follow index");
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_issue <= r_cnt))
        else $error("search ran past the unit's entry count");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |=> (r_count[$past(r_slot[SW-1:0])] <= CNT_W'(MAX_ENTRIES)))
        else $error("unit entry count exceeds store depth");
    a_search_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !o_pop)
        else $error("job taken while a search is running");
`endif

endmodule

`default_nettype wire

FILE: dv/memory_poison_list_recorder_top_test.sv
// ----------------------------------------------------------------------------
// memory_poison_list_recorder_top_test
// self-checking bench for the memory poison list recorder
// ----------------------------------------------------------------------------
//  A queue of machine-check reports feeds a driver that changes inputs on the
//  falling edge and holds i_start until an item is taken. The monitor samples
//  on the rising edge. It keeps a shadow copy of the poison list and predicts
//  one result for every item taken. It then checks each o_valid strobe, field
//  by field, against the oldest prediction. A short directed part covers the
//  special cases: ignored reports, duplicates that differ only in time, the
//  default limit, too many units, no units, a lowered limit and spare register
//  indexes. After it, random phases change the configuration between drains.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_poison_list_recorder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mprl_pkg::*;

    // run shape
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int SETTLE_CYCLES = 2 * (DEF_MAX_ENTRIES + 3);
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int HIST_DEPTH    = 40;
    localparam int MAX_REPORTS   = 10;

    // register indexes past the end of the map, the block must ignore them
    localparam logic [CFG_IX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IX_W-1:0] CFG_SPARE_7 = 3'd7;

    // one machine-check report
    typedef struct {
        logic              is_mem;
        logic [WORD_W-1:0] pkg_id;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] hw_id;
        logic [WORD_W-1:0] err_time;
    } t_mce_report;

    // one result of the recorder
    typedef struct {
        t_status           status;
        logic              retire;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  index;
        logic [CNT_W-1:0]  total;
    } t_poison_result;

    // ------------------------------------------------------------------------
    // clock, reset and ports
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // report channel, driven only by the driver block
    logic              i_start           = 1'b0;
    logic              i_is_memory_error = 1'b0;
    logic [WORD_W-1:0] i_package_id      = '0;
    logic [WORD_W-1:0] i_err_addr        = '0;
    logic [WORD_W-1:0] i_unit_hw_id      = '0;
    logic [WORD_W-1:0] i_err_time        = '0;

    // config channel, driven only by the sequence
    logic                i_cfg_valid = 1'b0;
    logic [CFG_IX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]   i_cfg_data  = '0;

    logic              o_busy;
    logic              o_valid;
    logic [2:0]        o_status;
    logic              o_retire_row;
    logic [SLOT_W-1:0] o_unit_slot;
    logic [CNT_W-1:0]  o_entry_index;
    logic [CNT_W-1:0]  o_entry_total;
    logic              o_cfg_ready;

    always #5 i_clk = ~i_clk;

    memory_poison_list_recorder_top #(
        .MAX_UNITS   (DEF_MAX_UNITS),
        .MAX_ENTRIES (DEF_MAX_ENTRIES)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_is_memory_error (i_is_memory_error),
        .i_package_id      (i_package_id),
        .i_err_addr        (i_err_addr),
        .i_unit_hw_id      (i_unit_hw_id),
        .i_err_time        (i_err_time),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_retire_row      (o_retire_row),
        .o_unit_slot       (o_unit_slot),
        .o_entry_index     (o_entry_index),
        .o_entry_total     (o_entry_total),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // shadow copy of configuration and poison list
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0]    sh_max_entries = CNT_W'(8);
    logic [UCOUNT_W-1:0] sh_unit_count  = UCOUNT_W'(1);
    logic [WORD_W-1:0]   sh_unit_id [NUM_UNIT_IDS];
    logic [CNT_W-1:0]    sh_count   [DEF_MAX_UNITS];
    logic [WORD_W-1:0]   sh_addr    [DEF_MAX_UNITS*DEF_MAX_ENTRIES];
    logic [WORD_W-1:0]   sh_hw_id   [DEF_MAX_UNITS*DEF_MAX_ENTRIES];
    logic [WORD_W-1:0]   sh_time    [DEF_MAX_UNITS*DEF_MAX_ENTRIES];

    // pending reports, predicted results, recent address / id pairs
    t_mce_report    report_q [$];
    t_poison_result predicted_q [$];
    logic [WORD_W-1:0] hist_addr [$];
    logic [WORD_W-1:0] hist_hw_id [$];

    t_mce_report drv_item;
    logic        item_taken      = 1'b0;
    int          sender_idle_pct = 0;

    int taken_count    = 0;
    int checked_count  = 0;
    int mismatch_count = 0;
    int fail_count     = 0;
    int phase_count    = 0;
    int status_seen [5];
    int cycle_count    = 0;

    initial begin
        foreach (sh_unit_id[s]) sh_unit_id[s] = '0;
        foreach (sh_count[u]) sh_count[u] = '0;
        foreach (status_seen[k]) status_seen[k] = 0;
    end

    // register write into the shadow copy, unknown indexes drop out
    function automatic void apply_reg(input logic [CFG_IX_W-1:0] idx,
                                      input logic [WORD_W-1:0] data);
        case (idx)
            CFG_MAX_ENTRIES: sh_max_entries = data[CNT_W-1:0];
            CFG_UNIT_COUNT:  sh_unit_count  = data[UCOUNT_W-1:0];
            CFG_UNIT_ID_0:   sh_unit_id[0]  = data;
            CFG_UNIT_ID_1:   sh_unit_id[1]  = data;
            CFG_UNIT_ID_2:   sh_unit_id[2]  = data;
            CFG_UNIT_ID_3:   sh_unit_id[3]  = data;
            default: ;
        endcase
    endfunction

    // classify one report and update the poison list, giving its result
    function automatic t_poison_result record_report(input t_mce_report rpt);
        t_poison_result res;
        int  units;
        int  slot;
        int  cnt;
        int  base;
        int  limit;
        int  dup_at;
        bit  found;
        res.status = ST_NOT_MEM;
        res.retire = 1'b0;
        res.slot   = '0;
        res.index  = '0;
        res.total  = '0;
        if (!rpt.is_mem) return res;

        // every memory error asks for row retirement
        res.retire = 1'b1;
        units = (int'(sh_unit_count) > DEF_MAX_UNITS) ? DEF_MAX_UNITS : int'(sh_unit_count);
        found = 1'b0;
        slot  = 0;
        for (int u = 0; u < units; u++) begin
            if (!found && sh_unit_id[u] == rpt.pkg_id) begin
                found = 1'b1;
                slot  = u;
            end
        end
        if (!found) begin
            res.status = ST_UNKNOWN;
            return res;
        end

        cnt = int'(sh_count[slot]);
        if (cnt > DEF_MAX_ENTRIES) cnt = DEF_MAX_ENTRIES;
        base = slot * DEF_MAX_ENTRIES;
        res.slot  = slot[SLOT_W-1:0];
        res.total = cnt[CNT_W-1:0];

        // held entries are matched on address and hw id, time ignored
        dup_at = -1;
        for (int i = 0; i < cnt; i++) begin
            if (dup_at < 0 && sh_addr[base+i] == rpt.addr && sh_hw_id[base+i] == rpt.hw_id)
                dup_at = i;
        end
        if (dup_at >= 0) begin
            res.status = ST_DUP;
            res.index  = dup_at[CNT_W-1:0];
            return res;
        end

        // zero means default limit, capped at store depth
        limit = (sh_max_entries == '0) ? DEFAULT_LIMIT : int'(sh_max_entries);
        if (limit > DEF_MAX_ENTRIES) limit = DEF_MAX_ENTRIES;
        if (cnt >= limit) begin
            res.status = ST_FULL;
            return res;
        end

        sh_addr[base+cnt]  = rpt.addr;
        sh_hw_id[base+cnt] = rpt.hw_id;
        sh_time[base+cnt]  = rpt.err_time;
        sh_count[slot]     = CNT_W'(cnt + 1);
        res.status = ST_STORED;
        res.index  = cnt[CNT_W-1:0];
        res.total  = CNT_W'(cnt + 1);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driver: new item on the falling edge once the last one was taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_mce_report nxt;
        if (i_rst_n && (!i_start || item_taken)) begin
            if (report_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                nxt = report_q.pop_front();
                drv_item          <= nxt;
                i_is_memory_error <= nxt.is_mem;
                i_package_id      <= nxt.pkg_id;
                i_err_addr        <= nxt.addr;
                i_unit_hw_id      <= nxt.hw_id;
                i_err_time        <= nxt.err_time;
                i_start           <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check strobed results, then predict for the item taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_poison_result want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (predicted_q.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("cycle %0d: result with nothing outstanding, status %0d",
                                 cycle_count, o_status);
                end else begin
                    want = predicted_q.pop_front();
                    checked_count++;
                    status_seen[int'(want.status)]++;
                    if (o_status !== want.status || o_retire_row !== want.retire ||
                        o_unit_slot !== want.slot || o_entry_index !== want.index ||
                        o_entry_total !== want.total) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"cycle %0d mismatch (exp/got): status %0d/%0d ",
                                      "retire %0b/%0b slot %0d/%0d index %0d/%0d ",
                                      "total %0d/%0d"},
                                     cycle_count, want.status, o_status,
                                     want.retire, o_retire_row, want.slot, o_unit_slot,
                                     want.index, o_entry_index, want.total, o_entry_total);
                    end
                end
            end
            // item handshake
            if (i_start && !o_busy) begin
                predicted_q.push_back(record_report(drv_item));
                taken_count++;
                item_taken <= 1'b1;
            end else begin
                item_taken <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // random word, sometimes all zeros or all ones
    function automatic logic [WORD_W-1:0] rand_word();
        int r;
        r = $urandom_range(99);
        if (r < 3) return '0;
        if (r < 6) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic void push_report(input logic is_mem, input logic [WORD_W-1:0] pkg,
                                        input logic [WORD_W-1:0] addr,
                                        input logic [WORD_W-1:0] hw_id,
                                        input logic [WORD_W-1:0] err_time);
        t_mce_report rpt;
        rpt.is_mem   = is_mem;
        rpt.pkg_id   = pkg;
        rpt.addr     = addr;
        rpt.hw_id    = hw_id;
        rpt.err_time = err_time;
        report_q.push_back(rpt);
    endfunction

    // random report: mostly known ids, often reused address / id pairs
    function automatic void push_random_report();
        logic [WORD_W-1:0] pkg;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] hw_id;
        int r;
        int k;
        pkg = ($urandom_range(99) < 80) ? sh_unit_id[$urandom_range(NUM_UNIT_IDS-1)]
                                        : rand_word();
        addr  = rand_word();
        hw_id = rand_word();
        r = $urandom_range(99);
        if (hist_addr.size() != 0 && r < 60) begin
            k = $urandom_range(hist_addr.size() - 1);
            if (r < 40) begin
                addr  = hist_addr[k];
                hw_id = hist_hw_id[k];
            end else if (r < 50) begin
                addr = hist_addr[k];
            end else begin
                hw_id = hist_hw_id[k];
            end
        end
        if (r >= 40) begin
            hist_addr.push_back(addr);
            hist_hw_id.push_back(hw_id);
            if (hist_addr.size() > HIST_DEPTH) begin
                void'(hist_addr.pop_front());
                void'(hist_hw_id.pop_front());
            end
        end
        push_report($urandom_range(99) < 88, pkg, addr, hw_id, rand_word());
    endfunction

    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until all items are taken and every result has come back
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (report_q.size() != 0 || i_start || predicted_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random setting of every register, extremes weighted in
    task automatic random_config();
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] id;
        int r;
        data = rand_word();
        case ($urandom_range(7))
            0:       data[CNT_W-1:0] = CNT_W'(0);
            1:       data[CNT_W-1:0] = CNT_W'(1);
            2:       data[CNT_W-1:0] = CNT_W'(DEF_MAX_ENTRIES);
            3:       data[CNT_W-1:0] = CNT_W'(255);
            4:       data[CNT_W-1:0] = CNT_W'($urandom_range(2, 15));
            5:       data[CNT_W-1:0] = CNT_W'($urandom_range(17, 254));
            default: data[CNT_W-1:0] = CNT_W'($urandom_range(4, 16));
        endcase
        write_reg(CFG_MAX_ENTRIES, data);

        data = rand_word();
        r = $urandom_range(9);
        if (r < 7)       data[UCOUNT_W-1:0] = UCOUNT_W'($urandom_range(1, 4));
        else if (r == 7) data[UCOUNT_W-1:0] = '0;
        else             data[UCOUNT_W-1:0] = UCOUNT_W'($urandom_range(5, 7));
        write_reg(CFG_UNIT_COUNT, data);

        // ids mostly kept so held entries stay reachable
        for (int s = 0; s < NUM_UNIT_IDS; s++) begin
            r  = $urandom_range(9);
            id = sh_unit_id[s];
            if (r < 2)       id = rand_word();
            else if (r == 2) id = sh_unit_id[$urandom_range(NUM_UNIT_IDS-1)];
            write_reg(t_cfg_index'(int'(CFG_UNIT_ID_0) + s), id);
        end
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, rand_word());
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : sequence_main
        logic [WORD_W-1:0] id_x;
        int idle_pattern [3];
        idle_pattern = '{0, 65, 15};
        id_x = {$urandom, $urandom};

        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset: limit 8, one unit with id zero
        sender_idle_pct = 0;
        push_report(1'b0, '1, '1, '1, '1);           // ignored report, all ones
        push_report(1'b0, '0, '0, '0, '0);           // ignored even with a known id
        push_report(1'b1, '0, '0, '0, '1);           // stored at 0
        push_report(1'b1, '0, '0, '0, '0);           // duplicate, time differs
        push_report(1'b1, '0, '0, '1, '0);           // same address, other hw id
        push_report(1'b1, '0, '1, '0, '1);           // stored at 2
        push_report(1'b1, '1, '1, '1, '0);           // unknown unit
        wait_idle();
        phase_count++;

        // default limit, too many units, repeated id with lowest slot winning
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, {$urandom, $urandom});
        write_reg(CFG_MAX_ENTRIES, {{(WORD_W-CNT_W){1'b1}}, CNT_W'(0)});
        write_reg(CFG_UNIT_COUNT, {{(WORD_W-UCOUNT_W){1'b0}}, UCOUNT_W'(7)});
        write_reg(CFG_UNIT_ID_0, '0);
        write_reg(CFG_UNIT_ID_1, '1);
        write_reg(CFG_UNIT_ID_2, id_x);
        write_reg(CFG_UNIT_ID_3, '1);
        push_report(1'b1, '1, {$urandom, $urandom}, {$urandom, $urandom}, '0);
        push_report(1'b1, id_x, {$urandom, $urandom}, {$urandom, $urandom}, '1);
        push_report(1'b1, '0, '1, '0, {$urandom, $urandom});
        // fill slot 0 up to the default limit, then one past it
        for (int k = 0; k < 6; k++)
            push_report(1'b1, '0, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom});
        wait_idle();
        phase_count++;

        // no units at all
        write_reg(CFG_MAX_ENTRIES, CNT_W'(2));
        write_reg(CFG_UNIT_COUNT, UCOUNT_W'(0));
        push_report(1'b1, '0, {$urandom, $urandom}, '0, '0);
        wait_idle();
        phase_count++;

        // limit lowered below the held count: full, but old entries still match
        write_reg(CFG_UNIT_COUNT, UCOUNT_W'(1));
        push_report(1'b1, '0, {$urandom, $urandom}, {$urandom, $urandom}, '0);
        push_report(1'b1, '0, '0, '1, {$urandom, $urandom});
        wait_idle();
        phase_count++;

        // largest limit, capped at store depth
        write_reg(CFG_MAX_ENTRIES, CNT_W'(255));
        push_report(1'b1, '0, {$urandom, $urandom}, {$urandom, $urandom}, '1);
        wait_idle();
        phase_count++;

        // random phases, each drained halfway so the sender waits on results
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config();
            sender_idle_pct = idle_pattern[p % 3];
            for (int k = 0; k < PHASE_ITEMS / 2; k++) push_random_report();
            wait_idle();
            for (int k = PHASE_ITEMS / 2; k < PHASE_ITEMS; k++) push_random_report();
            wait_idle();
            phase_count++;
        end

        $display("%0d reports taken over %0d config phases, %0d results checked",
                 taken_count, phase_count, checked_count);
        $display("stored %0d, duplicate %0d, full %0d, unknown unit %0d, not memory %0d",
                 status_seen[int'(ST_STORED)], status_seen[int'(ST_DUP)],
                 status_seen[int'(ST_FULL)], status_seen[int'(ST_UNKNOWN)],
                 status_seen[int'(ST_NOT_MEM)]);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: memory_poison_list_recorder_top.f
rtl/core/mprl_pkg.sv
rtl/core/mprl_front.sv
rtl/core/mprl_queue.sv
rtl/core/mprl_back.sv
rtl/core/memory_poison_list_recorder_top.sv
dv/memory_poison_list_recorder_top_test.sv
